// ===== hdl/dacc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal accumulator machine: shared package
// Word, address and code types, machine constants and the word splitter.
// ----------------------------------------------------------------------------
package dacc_pkg;

    localparam int unsigned MemWords = 100;
    localparam int unsigned AddrW    = $clog2(MemWords);
    localparam int unsigned WordW    = 10;
    localparam int unsigned WordMax  = 999;
    localparam int unsigned InsnInp  = 901;
    localparam int unsigned InsnOut  = 902;

    typedef logic [AddrW-1:0] t_addr;
    typedef logic [WordW-1:0] t_word;
    typedef logic [1:0]       t_opc;
    typedef logic [2:0]       t_err;
    typedef logic [3:0]       t_sel;

    // Item opcodes
    localparam t_opc OPC_LOAD    = 2'd0;
    localparam t_opc OPC_RESTART = 2'd1;
    localparam t_opc OPC_EXEC    = 2'd2;

    // Error codes
    localparam t_err ERR_NONE     = 3'd0;
    localparam t_err ERR_OVERFLOW = 3'd1;
    localparam t_err ERR_FETCH    = 3'd2;
    localparam t_err ERR_BAD_INSN = 3'd3;
    localparam t_err ERR_BAD_LOAD = 3'd4;

    // Instruction classes (hundreds digit)
    localparam t_sel SEL_HLT = 4'd0;
    localparam t_sel SEL_ADD = 4'd1;
    localparam t_sel SEL_SUB = 4'd2;
    localparam t_sel SEL_STA = 4'd3;
    localparam t_sel SEL_NOP = 4'd4;
    localparam t_sel SEL_LDA = 4'd5;
    localparam t_sel SEL_BRA = 4'd6;
    localparam t_sel SEL_BRZ = 4'd7;
    localparam t_sel SEL_BRP = 4'd8;
    localparam t_sel SEL_IO  = 4'd9;

    typedef struct packed {
        t_sel  sel;
        t_addr loc;
    } t_insn;

    // Outcome of one executed instruction
    typedef struct packed {
        t_addr pc;
        t_word acc;
        logic  neg;
        logic  halt;
        logic  emit;
        t_err  err;
        logic  wr_en;
    } t_exec_res;

    // Split a word into hundreds digit and two-digit address
    function automatic t_insn split_word(t_word w);
        t_insn res;
        t_sel  s;
        t_word base;
        s    = '0;
        base = '0;
        for (int i = 1; i <= 10; i++) begin
            if (w >= t_word'(i * 100)) begin
                s    = t_sel'(i);
                base = t_word'(i * 100);
            end
        end
        res.sel = s;
        res.loc = t_addr'(w - base);
        return res;
    endfunction

endpackage

// ===== hdl/dacc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal accumulator machine: channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface dacc_in_if import dacc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_opc  opcode;
    t_addr address;
    t_word load_data;
    t_word in_value;

    modport source (output valid, opcode, address, load_data, in_value, input ready);
    modport sink   (input valid, opcode, address, load_data, in_value, output ready);
endinterface

interface dacc_out_if import dacc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_addr pc_out;
    t_word acc_out;
    logic  neg_out;
    logic  halted_out;
    logic  out_valid;
    t_word out_value;
    t_err  error_code;

    modport source (output valid, pc_out, acc_out, neg_out, halted_out, out_valid,
                    out_value, error_code, input ready);
    modport sink   (input valid, pc_out, acc_out, neg_out, halted_out, out_valid,
                    out_value, error_code, output ready);
endinterface

// ===== hdl/decimal_accumulator_cpu_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal accumulator machine: top level
// Load, restart and single-step execution over a 100-word decimal memory.
// ----------------------------------------------------------------------------
// Load, restart, unused opcode and a step refused while halted or at pc 100
// register their result on transfer; an executed step goes through fetch and
// execute. One load or restart per cycle while the result channel is free; no
// item is taken in a step, whose fetch and operand reads share the one read port.
// Reset clears pc, accumulator, flags and the per-word valid bits, so every
// memory word reads as zero until written; no clearing pass is needed.
module decimal_accumulator_cpu_step_top import dacc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dacc_in_if.sink    i_in,
    dacc_out_if.source o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]          r_state, n_state;
    t_addr               r_pc, n_pc;
    t_word               r_acc, n_acc;
    logic                r_neg, n_neg;
    logic                r_halt, n_halt;
    logic                n_emit;
    t_err                n_err;
    logic                n_done;
    logic [MemWords-1:0] r_mem_vld;
    logic                r_rd_vld;
    t_word               r_in_value;
    t_word               r_word;
    t_insn               r_insn;

    logic                r_out_vld;
    t_addr               r_out_pc;
    t_word               r_out_acc;
    logic                r_out_neg;
    logic                r_out_halt;
    logic                r_out_emit;
    t_word               r_out_value;
    t_err                r_out_err;

    logic                w_out_free;
    logic                w_take;
    logic                w_load_ok;
    t_word               w_rdata;
    t_word               w_word;
    t_insn               w_fetch_insn;
    t_addr               w_raddr;
    logic                w_we;
    t_addr               w_waddr;
    t_word               w_wdata;
    t_exec_res           w_res;

    // Handshake
    assign w_out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_load_ok  = (i_in.address < t_addr'(MemWords))
                     && (i_in.load_data <= t_word'(WordMax));

    // Memory read: words never written read as zero
    assign w_word       = r_rd_vld ? w_rdata : '0;
    assign w_fetch_insn = split_word(w_word);

    always_comb begin
        case (r_state)
            S_FETCH: w_raddr = w_fetch_insn.loc;
            S_EXEC:  w_raddr = r_insn.loc;
            default: w_raddr = r_pc;
        endcase
    end

    // Memory write: load on transfer, store on instruction completion
    assign w_we = (w_take && i_in.opcode == OPC_LOAD && w_load_ok)
               || (r_state == S_EXEC && w_out_free && w_res.wr_en);
    assign w_waddr = (r_state == S_EXEC) ? r_insn.loc : i_in.address;
    assign w_wdata = (r_state == S_EXEC) ? r_acc : i_in.load_data;

    dacc_ram #(
        .Width (WordW),
        .Depth (MemWords)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dacc_exec u_exec (
        .i_insn     (r_insn),
        .i_word     (r_word),
        .i_operand  (w_word),
        .i_pc       (r_pc),
        .i_acc      (r_acc),
        .i_neg      (r_neg),
        .i_in_value (r_in_value),
        .o_res      (w_res)
    );

    // Sequencer and next machine state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_halt  = r_halt;
        n_emit  = 1'b0;
        n_err   = ERR_NONE;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    case (i_in.opcode)
                        OPC_LOAD: begin
                            n_done = 1'b1;
                            if (!w_load_ok) begin
                                n_err = ERR_BAD_LOAD;
                            end
                        end
                        OPC_RESTART: begin
                            n_done = 1'b1;
                            n_pc   = '0;
                            n_acc  = '0;
                            n_neg  = 1'b0;
                            n_halt = 1'b0;
                        end
                        OPC_EXEC: begin
                            if (r_halt) begin
                                n_done = 1'b1;
                            end else if (r_pc >= t_addr'(MemWords)) begin
                                n_done = 1'b1;
                                n_halt = 1'b1;
                                n_err  = ERR_FETCH;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_pc    = r_pc + t_addr'(1);
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_done  = 1'b1;
                    n_pc    = w_res.pc;
                    n_acc   = w_res.acc;
                    n_neg   = w_res.neg;
                    n_halt  = r_halt | w_res.halt;
                    n_emit  = w_res.emit;
                    n_err   = w_res.err;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_halt    <= 1'b0;
            r_mem_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_halt  <= n_halt;
            if (w_we) begin
                r_mem_vld[w_waddr] <= 1'b1;
            end
            if (n_done) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: read valid, latched item and decode, result register
    always_ff @(posedge i_clk) begin
        r_rd_vld <= (w_raddr < t_addr'(MemWords)) && r_mem_vld[w_raddr];
        if (w_take) begin
            r_in_value <= i_in.in_value;
        end
        if (r_state == S_FETCH) begin
            r_word <= w_word;
            r_insn <= w_fetch_insn;
        end
        if (n_done) begin
            r_out_pc    <= n_pc;
            r_out_acc   <= n_acc;
            r_out_neg   <= n_neg;
            r_out_halt  <= n_halt;
            r_out_emit  <= n_emit;
            r_out_value <= n_emit ? n_acc : '0;
            r_out_err   <= n_err;
        end
    end

    // Drive the result channel
    assign o_out.valid      = r_out_vld;
    assign o_out.pc_out     = r_out_pc;
    assign o_out.acc_out    = r_out_acc;
    assign o_out.neg_out    = r_out_neg;
    assign o_out.halted_out = r_out_halt;
    assign o_out.out_valid  = r_out_emit;
    assign o_out.out_value  = r_out_value;
    assign o_out.error_code = r_out_err;

endmodule

// ===== hdl/dacc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dacc_ram #(
    parameter int unsigned Width = 10,
    parameter int unsigned Depth = 100,
    localparam int unsigned AddrW = $clog2(Depth)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dacc_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal accumulator machine: execute unit
// Computes the new machine state for one decoded instruction and its operand.
// ----------------------------------------------------------------------------
module dacc_exec import dacc_pkg::*; (
    input  t_insn     i_insn,
    input  t_word     i_word,
    input  t_word     i_operand,
    input  t_addr     i_pc,
    input  t_word     i_acc,
    input  logic      i_neg,
    input  t_word     i_in_value,
    output t_exec_res o_res
);

    logic signed [11:0] w_acc_s;
    logic signed [11:0] w_sum;
    logic signed [11:0] w_diff;
    logic signed [11:0] w_diff_neg;
    logic signed [11:0] w_sum_max;
    t_word              w_diff_mag;

    // Signed add, and a subtract of the accumulator magnitude giving sign and magnitude
    assign w_acc_s    = i_neg ? -$signed({2'b00, i_acc}) : $signed({2'b00, i_acc});
    assign w_sum      = w_acc_s + $signed({2'b00, i_operand});
    assign w_diff     = $signed({2'b00, i_acc}) - $signed({2'b00, i_operand});
    assign w_diff_neg = -w_diff;
    assign w_diff_mag = w_diff[11] ? w_diff_neg[WordW-1:0] : w_diff[WordW-1:0];
    assign w_sum_max  = $signed({2'b00, t_word'(WordMax)});

    // Apply the instruction
    always_comb begin
        o_res       = '0;
        o_res.pc    = i_pc;
        o_res.acc   = i_acc;
        o_res.neg   = i_neg;
        o_res.err   = ERR_NONE;
        case (i_insn.sel)
            SEL_HLT: begin
                o_res.halt = 1'b1;
            end
            SEL_ADD: begin
                if (w_sum < 12'sd0 || w_sum > w_sum_max) begin
                    o_res.halt = 1'b1;
                    o_res.err  = ERR_OVERFLOW;
                end else begin
                    if (w_sum > 12'sd0) begin
                        o_res.neg = 1'b0;
                    end
                    o_res.acc = w_sum[WordW-1:0];
                end
            end
            SEL_SUB: begin
                o_res.neg = w_diff[11];
                o_res.acc = w_diff_mag;
            end
            SEL_STA: begin
                o_res.wr_en = 1'b1;
                o_res.neg   = 1'b0;
            end
            SEL_NOP: begin
                o_res.err = ERR_NONE;
            end
            SEL_LDA: begin
                o_res.acc = i_operand;
                o_res.neg = 1'b0;
            end
            SEL_BRA: begin
                o_res.pc = i_insn.loc;
            end
            SEL_BRZ: begin
                if (i_acc == '0) begin
                    o_res.pc = i_insn.loc;
                end
            end
            SEL_BRP: begin
                if (!i_neg) begin
                    o_res.pc = i_insn.loc;
                end
            end
            SEL_IO: begin
                if (i_word == t_word'(InsnInp)) begin
                    if (i_in_value > t_word'(WordMax)) begin
                        o_res.halt = 1'b1;
                        o_res.err  = ERR_OVERFLOW;
                    end else begin
                        o_res.acc = i_in_value;
                    end
                end else if (i_word == t_word'(InsnOut)) begin
                    o_res.emit = 1'b1;
                end else begin
                    o_res.halt = 1'b1;
                    o_res.err  = ERR_BAD_INSN;
                end
            end
            default: begin
                o_res.halt = 1'b1;
                o_res.err  = ERR_BAD_INSN;
            end
        endcase
    end

endmodule
